>>> rtl/tic_pkg.sv
package tic_pkg;

   localparam int NumLevels = 5;
   localparam int LevelW = 3;
   localparam int NumLanes = 6;
   localparam int DivStages = 6;
   localparam int DivSteps = 3;
   localparam int QuotW = DivStages * DivSteps;
   localparam int NumW = QuotW + 17;
   localparam int LaneDepth = 3 + DivStages + 1;

   localparam logic [NumLevels-1:0][15:0] LevelReset =
      {16'd384, 16'd768, 16'd1536, 16'd3072, 16'd6144};

   typedef struct packed {
      logic [15:0]        conc_a;
      logic [15:0]        conc_b;
      logic [15:0]        conc_c;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] bx;
      logic signed [15:0] by_coord;
      logic signed [15:0] bz;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
   } req_type;

   typedef struct packed {
      logic [2:0]         level_index;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] start_z;
      logic signed [15:0] end_x;
      logic signed [15:0] end_y;
      logic signed [15:0] end_z;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } vertex_type;

   typedef struct packed {
      logic [15:0]        ci;
      logic [15:0]        cj;
      logic [15:0]        lev;
      logic signed [15:0] pi;
      logic signed [15:0] pj;
   } lane_in_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic [LevelW-1:0] level;
   } ctl_type;

   function automatic logic crosses(input logic [15:0] ci, input logic [15:0] cj,
                                    input logic [15:0] lev);
      return ((ci < lev) && (lev < cj)) || ((cj < lev) && (lev < ci));
   endfunction

endpackage

>>> rtl/tic_front.sv
module tic_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  tic_pkg::req_type                        req_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [2:0]                              csr_index,
   input  logic [15:0]                             csr_data,
   output tic_pkg::ctl_type                        ctl,
   output tic_pkg::lane_in_type [tic_pkg::NumLanes-1:0] lane_in
);

   logic [tic_pkg::NumLevels-1:0][15:0] level_ff;
   tic_pkg::req_type                    tri_ff;
   logic [tic_pkg::NumLevels-1:0]       mask_ff, mask_in;
   logic [tic_pkg::NumLevels-1:0]       ssel_ff, ssel_in;
   logic [tic_pkg::NumLevels-1:0]       esel_ff, esel_in;
   logic                                active_ff;
   logic [tic_pkg::LevelW-1:0]          cnt_ff;
   tic_pkg::ctl_type                    ctl_ff, ctl_in;
   tic_pkg::lane_in_type [tic_pkg::NumLanes-1:0] lane_ff, lane_in_nx;
   logic                                accept;

   assign busy = active_ff && (cnt_ff != tic_pkg::LevelW'(tic_pkg::NumLevels - 1));
   assign accept = start && !busy;
   assign csr_ready = 1'b1;
   assign ctl = ctl_ff;
   assign lane_in = lane_ff;

   always_comb begin
      logic e12, e23, e31;
      for (int lv = 0; lv < tic_pkg::NumLevels; lv++) begin
         e12 = tic_pkg::crosses(req_data.conc_a, req_data.conc_b, level_ff[lv]);
         e23 = tic_pkg::crosses(req_data.conc_b, req_data.conc_c, level_ff[lv]);
         e31 = tic_pkg::crosses(req_data.conc_c, req_data.conc_a, level_ff[lv]);
         mask_in[lv] = (e12 || e23) && (e31 || (e12 && e23));
         ssel_in[lv] = !e12;
         esel_in[lv] = e31;
      end
   end

   always_comb begin
      tic_pkg::vertex_type va, vb, vc, si, sj, ei, ej;
      logic [15:0] csi, csj, cei, cej, lev;
      logic hi;
      va = '{x: tri_ff.ax, y: tri_ff.ay, z: tri_ff.az};
      vb = '{x: tri_ff.bx, y: tri_ff.by_coord, z: tri_ff.bz};
      vc = '{x: tri_ff.cx, y: tri_ff.cy, z: tri_ff.cz};
      lev = level_ff[cnt_ff];
      if (ssel_ff[cnt_ff]) begin
         si = vb; sj = vc; csi = tri_ff.conc_b; csj = tri_ff.conc_c;
      end else begin
         si = va; sj = vb; csi = tri_ff.conc_a; csj = tri_ff.conc_b;
      end
      if (esel_ff[cnt_ff]) begin
         ei = vc; ej = va; cei = tri_ff.conc_c; cej = tri_ff.conc_a;
      end else begin
         ei = vb; ej = vc; cei = tri_ff.conc_b; cej = tri_ff.conc_c;
      end
      hi = 1'b0;
      for (int k = 0; k < tic_pkg::NumLevels; k++) begin
         if ((tic_pkg::LevelW'(k) > cnt_ff) && mask_ff[k]) begin
            hi = 1'b1;
         end
      end
      ctl_in.valid = active_ff && mask_ff[cnt_ff];
      ctl_in.last  = !hi;
      ctl_in.level = cnt_ff;
      lane_in_nx[0] = '{ci: csi, cj: csj, lev: lev, pi: si.x, pj: sj.x};
      lane_in_nx[1] = '{ci: csi, cj: csj, lev: lev, pi: si.y, pj: sj.y};
      lane_in_nx[2] = '{ci: csi, cj: csj, lev: lev, pi: si.z, pj: sj.z};
      lane_in_nx[3] = '{ci: cei, cj: cej, lev: lev, pi: ei.x, pj: ej.x};
      lane_in_nx[4] = '{ci: cei, cj: cej, lev: lev, pi: ei.y, pj: ej.y};
      lane_in_nx[5] = '{ci: cei, cj: cej, lev: lev, pi: ei.z, pj: ej.z};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= tic_pkg::LevelReset;
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         ctl_ff    <= '0;
      end else begin
         if (csr_valid && (csr_index < 3'(tic_pkg::NumLevels))) begin
            level_ff[csr_index[tic_pkg::LevelW-1:0]] <= csr_data;
         end
         if (accept) begin
            active_ff <= 1'b1;
            cnt_ff    <= '0;
         end else if (active_ff) begin
            if (cnt_ff == tic_pkg::LevelW'(tic_pkg::NumLevels - 1)) begin
               active_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in_nx;
      if (accept) begin
         tri_ff  <= req_data;
         mask_ff <= mask_in;
         ssel_ff <= ssel_in;
         esel_ff <= esel_in;
      end
   end

endmodule

>>> rtl/tic_lane.sv
module tic_lane (
   input  logic                 clock,
   input  tic_pkg::lane_in_type lane_in,
   output logic signed [15:0]   point
);

   logic [15:0]        num_ff, den_ff, absd_ff;
   logic               neg_ff;
   logic signed [15:0] base_ff;

   logic [31:0]        mag_ff;
   logic [15:0]        mden_ff;
   logic               mneg_ff;
   logic signed [15:0] mbase_ff;

   logic [tic_pkg::NumW-1:0] an_ff;
   logic [16:0]              ad_ff;
   logic                     aneg_ff;
   logic signed [15:0]       abase_ff;

   logic [tic_pkg::DivStages-1:0][17:0]                rem_ff, rem_in;
   logic [tic_pkg::DivStages-1:0][tic_pkg::QuotW-1:0]  q_ff, q_in;
   logic [tic_pkg::DivStages-1:0][tic_pkg::NumW-1:0]   n_ff;
   logic [tic_pkg::DivStages-1:0][16:0]                d_ff;
   logic [tic_pkg::DivStages-1:0]                      neg_d_ff;
   logic [tic_pkg::DivStages-1:0][15:0]                base_d_ff;

   logic signed [15:0] point_ff;

   logic [15:0]        num_in, den_in, absd_in;
   logic signed [16:0] diff;

   assign point = point_ff;

   always_comb begin
      if (lane_in.ci < lane_in.lev) begin
         num_in = lane_in.lev - lane_in.ci;
         den_in = lane_in.cj - lane_in.ci;
      end else begin
         num_in = lane_in.ci - lane_in.lev;
         den_in = lane_in.ci - lane_in.cj;
      end
      diff = 17'(lane_in.pj) - 17'(lane_in.pi);
      absd_in = diff[16] ? 16'(-diff) : diff[15:0];
   end

   always_comb begin
      logic [17:0] r;
      logic [tic_pkg::QuotW-1:0] q;
      logic [tic_pkg::NumW-1:0] n;
      logic [16:0] d;
      for (int s = 0; s < tic_pkg::DivStages; s++) begin
         if (s == 0) begin
            n = an_ff;
            d = ad_ff;
            r = {1'b0, an_ff[tic_pkg::NumW-1:tic_pkg::QuotW]};
            q = '0;
         end else begin
            n = n_ff[s-1];
            d = d_ff[s-1];
            r = rem_ff[s-1];
            q = q_ff[s-1];
         end
         for (int t = 0; t < tic_pkg::DivSteps; t++) begin
            r = {r[16:0], n[tic_pkg::QuotW - 1 - s * tic_pkg::DivSteps - t]};
            if (r >= {1'b0, d}) begin
               r = r - {1'b0, d};
               q[tic_pkg::QuotW - 1 - s * tic_pkg::DivSteps - t] = 1'b1;
            end
         end
         rem_in[s] = r;
         q_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      logic [17:0] qs;
      num_ff  <= num_in;
      den_ff  <= den_in;
      absd_ff <= absd_in;
      neg_ff  <= diff[16];
      base_ff <= lane_in.pi;

      mag_ff   <= num_ff * absd_ff;
      mden_ff  <= den_ff;
      mneg_ff  <= neg_ff;
      mbase_ff <= base_ff;

      an_ff    <= {2'b00, mag_ff, 1'b0} + tic_pkg::NumW'(mden_ff);
      ad_ff    <= {mden_ff, 1'b0};
      aneg_ff  <= mneg_ff;
      abase_ff <= mbase_ff;

      for (int s = 0; s < tic_pkg::DivStages; s++) begin
         rem_ff[s] <= rem_in[s];
         q_ff[s]   <= q_in[s];
         if (s == 0) begin
            n_ff[s]      <= an_ff;
            d_ff[s]      <= ad_ff;
            neg_d_ff[s]  <= aneg_ff;
            base_d_ff[s] <= abase_ff;
         end else begin
            n_ff[s]      <= n_ff[s-1];
            d_ff[s]      <= d_ff[s-1];
            neg_d_ff[s]  <= neg_d_ff[s-1];
            base_d_ff[s] <= base_d_ff[s-1];
         end
      end

      qs = q_ff[tic_pkg::DivStages-1][17:0];
      if (neg_d_ff[tic_pkg::DivStages-1]) begin
         point_ff <= 16'({{2{base_d_ff[tic_pkg::DivStages-1][15]}},
                          base_d_ff[tic_pkg::DivStages-1]} - qs);
      end else begin
         point_ff <= 16'({{2{base_d_ff[tic_pkg::DivStages-1][15]}},
                          base_d_ff[tic_pkg::DivStages-1]} + qs);
      end
   end

endmodule

>>> rtl/triangle_isoline_crossings.sv
// Contour segment extractor for one triangle per beat.
// Input: a beat is taken on a rising edge with start high and busy low;
// req_data holds three vertex concentrations (Q8.8) and positions (Q12.4).
// Config: csr_valid/csr_ready write csr_data into contour level csr_index
// (0..4); indexes 5..7 are ignored. csr_ready is always high. Write only
// while no triangle is in flight.
// Output: one beat per segment, rsp_valid high for one cycle, levels in
// increasing order, rsp_data.last on the final segment of a triangle.
// Triangles with no segment give no beat.
// Throughput: one contour level per cycle through the datapath; busy
// drops during the last level of a triangle so the next one follows
// without a gap.
// Pipeline: each contour level passes the pipelined long divider (6 stages
// of 3 quotient bits) plus operand, multiply, sum and rounding stages.
// Reset: synchronous; levels return to 24.0, 12.0, 6.0, 3.0, 1.5 and all
// in-flight work is dropped. The receiver cannot stall the output.
module triangle_isoline_crossings (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tic_pkg::req_type req_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data,
   output logic             rsp_valid,
   output tic_pkg::rsp_type rsp_data
);

   tic_pkg::ctl_type                             ctl;
   tic_pkg::lane_in_type [tic_pkg::NumLanes-1:0] lane_in;
   logic signed [15:0]                           pt [tic_pkg::NumLanes];
   tic_pkg::ctl_type [tic_pkg::LaneDepth-1:0]    ctl_ff;

   tic_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctl       (ctl),
      .lane_in   (lane_in)
   );

   for (genvar g = 0; g < tic_pkg::NumLanes; g++) begin : g_lane
      tic_lane u_lane (
         .clock   (clock),
         .lane_in (lane_in[g]),
         .point   (pt[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= {ctl_ff[tic_pkg::LaneDepth-2:0], ctl};
      end
   end

   assign rsp_valid = ctl_ff[tic_pkg::LaneDepth-1].valid;

   always_comb begin
      rsp_data.level_index = ctl_ff[tic_pkg::LaneDepth-1].level;
      rsp_data.start_x     = pt[0];
      rsp_data.start_y     = pt[1];
      rsp_data.start_z     = pt[2];
      rsp_data.end_x       = pt[3];
      rsp_data.end_y       = pt[4];
      rsp_data.end_z       = pt[5];
      rsp_data.last        = ctl_ff[tic_pkg::LaneDepth-1].last;
   end

endmodule

>>> tb/sv/tb_triangle_isoline_crossings.sv
`timescale 1ns / 1ps

module tb_triangle_isoline_crossings;

   localparam int Drain = 40;
   localparam int CycleLimit = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   tic_pkg::req_type req_data = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;
   logic rsp_valid;
   tic_pkg::rsp_type rsp_data;

   triangle_isoline_crossings dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [15:0] levels [tic_pkg::NumLevels];
   tic_pkg::req_type tri_queue [$];
   tic_pkg::rsp_type segment_queue [$];
   int errors = 0;
   int cycles = 0;
   int gap = 0;
   bit hold = 0;
   int accepted = 0;

   // sampled at rising edge for the driver's acceptance check
   logic busy_q = 1'b0;
   always @(posedge clock) busy_q <= busy;

   function automatic bit edge_point(input int ci, input int cj, input int lev,
                                     input tic_pkg::vertex_type vi,
                                     input tic_pkg::vertex_type vj,
                                     output tic_pkg::vertex_type pt);
      longint num, den, prod, mag, q;
      longint a [3];
      longint b [3];
      if (!((ci < lev && lev < cj) || (cj < lev && lev < ci))) return 0;
      num = lev - ci;
      den = cj - ci;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      a[0] = vi.x; a[1] = vi.y; a[2] = vi.z;
      b[0] = vj.x; b[1] = vj.y; b[2] = vj.z;
      for (int k = 0; k < 3; k++) begin
         prod = num * (b[k] - a[k]);
         mag = prod < 0 ? -prod : prod;
         q = (2 * mag + den) / (2 * den);
         if (prod < 0) q = -q;
         a[k] = a[k] + q;
      end
      pt.x = 16'(a[0]);
      pt.y = 16'(a[1]);
      pt.z = 16'(a[2]);
      return 1;
   endfunction

   function automatic void predict_segments(input tic_pkg::req_type t);
      tic_pkg::vertex_type va, vb, vc, s, e, p;
      bit has_s, has_e;
      int n;
      tic_pkg::rsp_type r;
      va = '{t.ax, t.ay, t.az};
      vb = '{t.bx, t.by_coord, t.bz};
      vc = '{t.cx, t.cy, t.cz};
      n = 0;
      for (int lv = 0; lv < tic_pkg::NumLevels; lv++) begin
         has_s = 0;
         has_e = 0;
         if (edge_point(t.conc_a, t.conc_b, levels[lv], va, vb, p)) begin
            s = p;
            has_s = 1;
         end
         if (edge_point(t.conc_b, t.conc_c, levels[lv], vb, vc, p)) begin
            if (!has_s) begin
               s = p;
               has_s = 1;
            end else begin
               e = p;
               has_e = 1;
            end
         end
         if (edge_point(t.conc_c, t.conc_a, levels[lv], vc, va, p)) begin
            e = p;
            has_e = 1;
         end
         if (has_s && has_e) begin
            r.level_index = 3'(lv);
            r.start_x = s.x; r.start_y = s.y; r.start_z = s.z;
            r.end_x = e.x; r.end_y = e.y; r.end_z = e.z;
            r.last = 1'b0;
            segment_queue.insert(segment_queue.size(), r);
            n++;
         end
      end
      if (n > 0) segment_queue[$].last = 1'b1;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy_q) begin
            predict_segments(req_data);
            accepted++;
            void'(tri_queue.pop_front());
         end
         if (start && busy_q) begin
            // hold item
         end else if (tri_queue.size() == 0 || (hold && segment_queue.size() != 0)) begin
            start <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            start <= 1'b0;
         end else begin
            req_data <= tri_queue[0];
            start <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 4);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (segment_queue.size() == 0) begin
            $display("%0t unexpected segment %h", $time, rsp_data);
            errors++;
         end else begin
            if (rsp_data !== segment_queue[0]) begin
               $display("%0t mismatch expected %h actual %h", $time,
                        segment_queue[0], rsp_data);
               errors++;
            end
            void'(segment_queue.pop_front());
         end
      end
      if (cycles > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic tic_pkg::req_type rand_tri(input bit wild);
      tic_pkg::req_type t;
      t = tic_pkg::req_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom});
      if (!wild) begin
         t.conc_a = 16'($urandom_range(0, 8000));
         t.conc_b = 16'($urandom_range(0, 8000));
         t.conc_c = 16'($urandom_range(0, 8000));
      end
      return t;
   endfunction

   function automatic void add_tri(input tic_pkg::req_type t);
      tri_queue.insert(tri_queue.size(), t);
   endfunction

   task automatic wait_idle();
      while (tri_queue.size() != 0 || start || segment_queue.size() != 0)
         @(posedge clock);
      repeat (Drain) @(posedge clock);
   endtask

   task automatic write_level(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < tic_pkg::NumLevels) levels[idx] = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_levels(input logic [15:0] a, b, c, d, e);
      write_level(3'd0, a);
      write_level(3'd1, b);
      write_level(3'd2, c);
      write_level(3'd3, d);
      write_level(3'd4, e);
   endtask

   function automatic tic_pkg::req_type tri_of(input logic [15:0] a, b, c,
                                               input logic signed [15:0] p);
      tic_pkg::req_type t;
      t = rand_tri(0);
      t.conc_a = a; t.conc_b = b; t.conc_c = c;
      t.ax = p; t.ay = -p; t.az = 16'sd0;
      t.bx = -p; t.by_coord = p; t.bz = 16'sh7fff;
      t.cx = 16'sh8000; t.cy = 16'sd0; t.cz = p;
      return t;
   endfunction

   initial begin
      for (int i = 0; i < tic_pkg::NumLevels; i++) levels[i] = tic_pkg::LevelReset[i];
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset levels
      add_tri(tri_of(16'd0, 16'hffff, 16'd100, 16'sh7fff));
      add_tri(tri_of(16'hffff, 16'd0, 16'd0, 16'sh8000));
      add_tri(tri_of(16'd1000, 16'd1000, 16'd1000, 16'sd5));
      add_tri(tri_of(16'd6144, 16'd0, 16'd8000, 16'sd100));
      add_tri(tri_of(16'd6144, 16'd6144, 16'd0, 16'sd0));
      add_tri(tri_of(16'd0, 16'd7000, 16'd0, 16'sd0));
      add_tri(tri_of(16'd2000, 16'd100, 16'd7000, -16'sd3));
      add_tri(tri_of(16'd385, 16'd383, 16'd385, 16'sd7));
      wait_idle();

      set_levels(16'd0, 16'hffff, 16'd1, 16'hfffe, 16'h8000);
      write_level(3'd5, 16'h1234);
      write_level(3'd7, 16'h0);
      add_tri(tri_of(16'd0, 16'hffff, 16'h8000, 16'sh7fff));
      add_tri(tri_of(16'hffff, 16'd0, 16'd2, 16'sh8000));
      add_tri(tri_of(16'd0, 16'd2, 16'hffff, 16'sd1));
      wait_idle();

      set_levels(16'd100, 16'd200, 16'd300, 16'd400, 16'd500);
      hold = 1;
      for (int i = 0; i < 50; i++) begin
         tic_pkg::req_type t;
         t = rand_tri(0);
         t.conc_a = 16'($urandom_range(0, 700));
         t.conc_b = 16'($urandom_range(0, 700));
         t.conc_c = 16'($urandom_range(0, 700));
         add_tri(t);
      end
      wait_idle();
      hold = 0;

      set_levels(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
      for (int i = 0; i < 30; i++) add_tri(rand_tri(1));
      wait_idle();

      set_levels(16'd6144, 16'd3072, 16'd1536, 16'd768, 16'd384);
      for (int i = 0; i < 50; i++) add_tri(rand_tri($urandom_range(0, 4) == 0));
      wait_idle();

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
